@@ rtl/core/assert_macros.svh @@
// Assertion helper macros for the product IIR filter RTL.
// Included by every module that carries concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/piir4_pkg.sv @@
// Shared types and constants for the product IIR filter.
// No dependencies; imported by piir4_mul, piir4_core and the top level.
`default_nettype none

package piir4_pkg;

   // Field and datapath widths
   localparam int SAMPLE_BITS   = 12;
   localparam int FRAC_BITS_DEF = 24;
   localparam int COEF_W        = 28;
   localparam int COEF_FRAC     = 24;
   localparam int HIST_W        = 40;
   localparam int HIST_DEPTH    = 4;
   localparam int DAC_W         = 12;
   localparam int NUM_COEF      = 7;
   localparam int MAC_STEPS     = 2 * NUM_COEF;
   localparam int CSR_IDX_W     = 3;
   localparam int MUL_W         = 33;
   localparam int PROD_W        = 2 * MUL_W;
   localparam int ACC_W         = 72;
   localparam int Q_W           = 18;

   // Code scaling: code = floor(q / 33), q = floor(w * 40960 / 2^frac)
   localparam logic [15:0]      DAC_GAIN     = 16'd40960;
   localparam logic [Q_W-1:0]   RECIP_K      = 18'd254201;
   localparam int               RECIP_SHIFT  = 23;
   localparam logic [DAC_W-1:0] DAC_MAX      = 12'd4095;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B4 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_A3 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_A4 = 3'd6;

   // Coefficient reset values, Q3.24
   localparam logic signed [COEF_W-1:0] B0_RST = 28'sd16777;
   localparam logic signed [COEF_W-1:0] B2_RST = -28'sd33554;
   localparam logic signed [COEF_W-1:0] B4_RST = 28'sd16777;
   localparam logic signed [COEF_W-1:0] A1_RST = 28'sd53116666;
   localparam logic signed [COEF_W-1:0] A2_RST = -28'sd74121740;
   localparam logic signed [COEF_W-1:0] A3_RST = 28'sd50801410;
   localparam logic signed [COEF_W-1:0] A4_RST = -28'sd15351153;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_first;
      logic [SAMPLE_BITS-1:0] sample_second;
   } req_type;

   typedef struct packed {
      logic [DAC_W-1:0] dac_code;
      logic             clipped;
   } rsp_type;

   typedef struct packed {
      logic [COEF_W-1:0] b0;
      logic [COEF_W-1:0] b2;
      logic [COEF_W-1:0] b4;
      logic [COEF_W-1:0] a1;
      logic [COEF_W-1:0] a2;
      logic [COEF_W-1:0] a3;
      logic [COEF_W-1:0] a4;
   } coef_set_type;

   // Top level to core
   typedef struct packed {
      logic start;
      logic hold;
   } core_ctl_type;

   // Core to top level
   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

endpackage

`default_nettype wire

@@ rtl/core/product_iir4_filter_unit.sv @@
// Top level: handshakes, coefficient registers, result register.
// Depends on piir4_pkg, piir4_core and assert_macros.svh.
//
//   beat     ports                               moves
//   -------  ----------------------------------  ------------------------------
//   request  req_valid / req_ready / req_data    two converter codes
//   result   rsp_valid / rsp_ready / rsp_data    DAC code and clip flag
//   config   csr_we / csr_index / csr_wdata      one Q3.24 coefficient write
//
// An item makes 19 passes through the shared 33x33 multiplier between acceptance and
// rsp_valid (two volt scalings, the volt product, fourteen half-width tap products,
// code scaling, divide by 33) plus fill and rounding steps; clipped codes skip the
// last three steps. req_ready is high while the core is idle; a held result stalls
// the core at its end, not the input. Synchronous active-high reset clears histories
// and handshakes and loads the default coefficients.
`default_nettype none

`include "assert_macros.svh"

module product_iir4_filter_unit #(
   parameter int FRAC_BITS = piir4_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire piir4_pkg::req_type                     req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output piir4_pkg::rsp_type                          rsp_data,
   input  wire logic                                   csr_we,
   input  wire logic [piir4_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [piir4_pkg::COEF_W-1:0]           csr_wdata
);
   import piir4_pkg::*;

   coef_set_type coef_ff, coef_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   core_ctl_type core_ctl;
   core_sts_type core_sts;
   rsp_type      core_result;

   piir4_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .ctl    (core_ctl),
      .req    (req_data),
      .coef   (coef_ff),
      .sts    (core_sts),
      .result (core_result)
   );

   assign req_ready     = !core_sts.busy;
   assign core_ctl.start = req_valid && req_ready;
   assign core_ctl.hold  = rsp_valid_ff && !rsp_ready;

   // coefficient write decode; unknown indexes are dropped
   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_B0:  coef_in.b0 = csr_wdata;
            CSR_B2:  coef_in.b2 = csr_wdata;
            CSR_B4:  coef_in.b4 = csr_wdata;
            CSR_A1:  coef_in.a1 = csr_wdata;
            CSR_A2:  coef_in.a2 = csr_wdata;
            CSR_A3:  coef_in.a3 = csr_wdata;
            CSR_A4:  coef_in.a4 = csr_wdata;
            default: coef_in = coef_ff;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (core_sts.done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0   <= B0_RST;
         coef_ff.b2   <= B2_RST;
         coef_ff.b4   <= B4_RST;
         coef_ff.a1   <= A1_RST;
         coef_ff.a2   <= A2_RST;
         coef_ff.a3   <= A3_RST;
         coef_ff.a4   <= A4_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_NEXT(a_start_busy, clock, reset, core_ctl.start, core_sts.busy, "no core start")
   `ASSERT_IMPL(a_no_clobber, clock, reset, core_sts.done, !rsp_valid || rsp_ready, "beat lost")
   `ASSERT_NEXT(a_drain, clock, reset, rsp_ready && !core_sts.done, !rsp_valid, "beat shown twice")

endmodule

`default_nettype wire

@@ rtl/core/piir4_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on piir4_pkg for operand and product widths.
`default_nettype none

module piir4_mul (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [piir4_pkg::MUL_W-1:0]  op_a,
   input  wire logic signed [piir4_pkg::MUL_W-1:0]  op_b,
   output logic signed      [piir4_pkg::PROD_W-1:0] prod
);
   import piir4_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // full-width signed product
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

@@ rtl/core/piir4_core.sv @@
// Sequencer and datapath: volts, product, seven-tap IIR sum and DAC code.
// Depends on piir4_pkg and the shared multiplier piir4_mul.
`default_nettype none

module piir4_core #(
   parameter int FRAC_BITS = piir4_pkg::FRAC_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire piir4_pkg::core_ctl_type ctl,
   input  wire piir4_pkg::req_type      req,
   input  wire piir4_pkg::coef_set_type coef,
   output piir4_pkg::core_sts_type      sts,
   output piir4_pkg::rsp_type           result
);
   import piir4_pkg::*;

   localparam int V_W = FRAC_BITS + 2;
   localparam int Y_W = ACC_W - COEF_FRAC;
   localparam int W_W = HIST_W + 1;
   localparam logic [63:0] VREF_Q  = ((64'd33 << FRAC_BITS) + 64'd5) / 64'd10;
   localparam logic [63:0] W_CEIL  = ((64'd33 << FRAC_BITS) + 64'd9) / 64'd10;
   localparam logic [63:0] V_HALF  = 64'd1 << (SAMPLE_BITS - 1);
   localparam logic [63:0] X_HALF  = 64'd1 << (FRAC_BITS - 1);
   localparam logic signed [W_W-1:0]   W_LIM     = W_W'(W_CEIL);
   localparam logic signed [W_W-1:0]   ONE_V     = W_W'(64'd1 << FRAC_BITS);
   localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(64'd1 << (COEF_FRAC - 1));
   localparam logic [3:0] MAC_LAST_CNT = 4'(MAC_STEPS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_VOLT_A, S_VOLT_B, S_VOLT_WAIT, S_PROD, S_XVAL, S_MAC, S_MAC_LAST,
      S_ROUND, S_OFFSET, S_RANGE, S_QUOT, S_RECIP, S_CODE, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [3:0]                    mac_cnt_ff, mac_cnt_in;
   logic                          hi_tag_ff, hi_tag_in;
   logic [SAMPLE_BITS-1:0]        samp_a_ff, samp_a_in, samp_b_ff, samp_b_in;
   logic [V_W-1:0]                v1_ff, v1_in, v2_ff, v2_in;
   logic signed [HIST_W-1:0]      x_ff, x_in, y_ff, y_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [W_W-1:0]         w_ff, w_in;
   logic [Q_W-1:0]                q_ff, q_in;
   logic [DAC_W-1:0]              code_ff, code_in;
   logic                          clip_ff, clip_in;
   logic signed [HIST_W-1:0]      in_hist_ff [HIST_DEPTH];
   logic signed [HIST_W-1:0]      in_hist_in [HIST_DEPTH];
   logic signed [HIST_W-1:0]      out_hist_ff [HIST_DEPTH];
   logic signed [HIST_W-1:0]      out_hist_in [HIST_DEPTH];

   logic                          mul_en;
   logic signed [MUL_W-1:0]       mul_a, mul_b;
   logic signed [PROD_W-1:0]      prod;
   logic [PROD_W-1:0]             prod_u;
   logic signed [ACC_W-1:0]       prod_ext;
   logic signed [COEF_W-1:0]      mac_coef;
   logic signed [HIST_W-1:0]      mac_hist;
   logic signed [Y_W-1:0]         y_full;
   logic [Y_W-HIST_W:0]           y_upper;

   piir4_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign prod_u   = prod;
   assign prod_ext = ACC_W'(prod);
   assign y_full   = Y_W'(acc_ff >>> COEF_FRAC);
   assign y_upper  = y_full[Y_W-1:HIST_W-1];

   // coefficient and history word for the current tap pair
   always_comb begin
      case (mac_cnt_ff[3:1])
         3'd0:    begin mac_coef = $signed(coef.b0); mac_hist = x_ff;           end
         3'd1:    begin mac_coef = $signed(coef.b2); mac_hist = in_hist_ff[1];  end
         3'd2:    begin mac_coef = $signed(coef.b4); mac_hist = in_hist_ff[3];  end
         3'd3:    begin mac_coef = $signed(coef.a1); mac_hist = out_hist_ff[0]; end
         3'd4:    begin mac_coef = $signed(coef.a2); mac_hist = out_hist_ff[1]; end
         3'd5:    begin mac_coef = $signed(coef.a3); mac_hist = out_hist_ff[2]; end
         default: begin mac_coef = $signed(coef.a4); mac_hist = out_hist_ff[3]; end
      endcase
   end

   // sequencer: issue to the multiplier, consume the registered product in the next cycle
   always_comb begin
      state_in   = state_ff;
      mac_cnt_in = mac_cnt_ff;
      hi_tag_in  = hi_tag_ff;
      samp_a_in  = samp_a_ff;
      samp_b_in  = samp_b_ff;
      v1_in      = v1_ff;
      v2_in      = v2_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      acc_in     = acc_ff;
      w_in       = w_ff;
      q_in       = q_ff;
      code_in    = code_ff;
      clip_in    = clip_ff;
      in_hist_in  = in_hist_ff;
      out_hist_in = out_hist_ff;
      mul_en     = 1'b0;
      mul_a      = '0;
      mul_b      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               samp_a_in = req.sample_first;
               samp_b_in = req.sample_second;
               state_in  = S_VOLT_A;
            end
         end
         S_VOLT_A: begin
            mul_en   = 1'b1;
            mul_a    = $signed(MUL_W'(samp_a_ff));
            mul_b    = $signed(MUL_W'(VREF_Q));
            state_in = S_VOLT_B;
         end
         S_VOLT_B: begin
            v1_in    = V_W'((prod_u + PROD_W'(V_HALF)) >> SAMPLE_BITS);
            mul_en   = 1'b1;
            mul_a    = $signed(MUL_W'(samp_b_ff));
            mul_b    = $signed(MUL_W'(VREF_Q));
            state_in = S_VOLT_WAIT;
         end
         S_VOLT_WAIT: begin
            v2_in    = V_W'((prod_u + PROD_W'(V_HALF)) >> SAMPLE_BITS);
            state_in = S_PROD;
         end
         S_PROD: begin
            mul_en   = 1'b1;
            mul_a    = $signed(MUL_W'(v1_ff));
            mul_b    = $signed(MUL_W'(v2_ff));
            state_in = S_XVAL;
         end
         S_XVAL: begin
            x_in       = HIST_W'((prod_u + PROD_W'(X_HALF)) >> FRAC_BITS);
            acc_in     = ACC_ROUND;
            mac_cnt_in = '0;
            state_in   = S_MAC;
         end
         S_MAC: begin
            // even step: low 24 bits of the history word; odd step: high part
            if (mac_cnt_ff != '0) begin
               acc_in = acc_ff + (hi_tag_ff ? (prod_ext <<< COEF_FRAC) : prod_ext);
            end
            mul_en    = 1'b1;
            mul_a     = MUL_W'(mac_coef);
            hi_tag_in = mac_cnt_ff[0];
            if (mac_cnt_ff[0]) begin
               mul_b = MUL_W'($signed(mac_hist[HIST_W-1:COEF_FRAC]));
            end else begin
               mul_b = $signed(MUL_W'(mac_hist[COEF_FRAC-1:0]));
            end
            if (mac_cnt_ff == MAC_LAST_CNT) begin
               state_in = S_MAC_LAST;
            end else begin
               mac_cnt_in = mac_cnt_ff + 4'd1;
            end
         end
         S_MAC_LAST: begin
            acc_in   = acc_ff + (hi_tag_ff ? (prod_ext <<< COEF_FRAC) : prod_ext);
            state_in = S_ROUND;
         end
         S_ROUND: begin
            // saturate to the history range, then shift both histories
            if (y_upper == '0 || y_upper == '1) begin
               y_in = y_full[HIST_W-1:0];
            end else if (y_full[Y_W-1]) begin
               y_in = {1'b1, {(HIST_W-1){1'b0}}};
            end else begin
               y_in = {1'b0, {(HIST_W-1){1'b1}}};
            end
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
               in_hist_in[i]  = in_hist_ff[i-1];
               out_hist_in[i] = out_hist_ff[i-1];
            end
            in_hist_in[0]  = x_ff;
            out_hist_in[0] = y_in;
            state_in       = S_OFFSET;
         end
         S_OFFSET: begin
            w_in     = W_W'(y_ff) + ONE_V;
            state_in = S_RANGE;
         end
         S_RANGE: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, w_ff[MUL_W-2:0]});
            mul_b  = $signed(MUL_W'(DAC_GAIN));
            if (w_ff[W_W-1]) begin
               code_in  = '0;
               clip_in  = 1'b1;
               state_in = S_FINISH;
            end else if (w_ff >= W_LIM) begin
               code_in  = DAC_MAX;
               clip_in  = 1'b1;
               state_in = S_FINISH;
            end else begin
               clip_in  = 1'b0;
               state_in = S_QUOT;
            end
         end
         S_QUOT: begin
            q_in     = Q_W'(prod_u >> FRAC_BITS);
            state_in = S_RECIP;
         end
         S_RECIP: begin
            // divide by 33 through the reciprocal multiply
            mul_en   = 1'b1;
            mul_a    = $signed(MUL_W'(q_ff));
            mul_b    = $signed(MUL_W'(RECIP_K));
            state_in = S_CODE;
         end
         S_CODE: begin
            code_in  = DAC_W'(prod_u >> RECIP_SHIFT);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!ctl.hold) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mac_cnt_ff <= '0;
         hi_tag_ff  <= 1'b0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            in_hist_ff[i]  <= '0;
            out_hist_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         mac_cnt_ff  <= mac_cnt_in;
         hi_tag_ff   <= hi_tag_in;
         in_hist_ff  <= in_hist_in;
         out_hist_ff <= out_hist_in;
      end
      samp_a_ff <= samp_a_in;
      samp_b_ff <= samp_b_in;
      v1_ff     <= v1_in;
      v2_ff     <= v2_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      acc_ff    <= acc_in;
      w_ff      <= w_in;
      q_ff      <= q_in;
      code_ff   <= code_in;
      clip_ff   <= clip_in;
   end

   assign sts.busy        = (state_ff != S_IDLE);
   assign sts.done        = (state_ff == S_FINISH) && !ctl.hold;
   assign result.dac_code = code_ff;
   assign result.clipped  = clip_ff;

endmodule

`default_nettype wire
